// ----- rtl/vz_pkg.sv -----
// ----------------------------------------------------------------------------
// vz_pkg
// Shared types, constants and helper functions for the LEB128 varint decoder
// with optional zigzag signed decode.
// ----------------------------------------------------------------------------
package vz_pkg;

  localparam logic [7:0] CONT_BIT   = 8'h80;
  localparam logic [6:0] GROUP_MASK = 7'h7F;
  localparam logic [6:0] GROUP_BITS = 7'd7;
  localparam logic [6:0] SHIFT_LIM  = 7'd64;
  localparam logic [7:0] COUNT_MAX  = 8'hFF;

  localparam logic [1:0] WSEL_16 = 2'd0;
  localparam logic [1:0] WSEL_32 = 2'd1;
  localparam logic [1:0] WSEL_64 = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
    logic [1:0] width_sel;
    logic       zigzag;
  } in_t;

  typedef struct packed {
    logic [63:0] value;
    logic [7:0]  byte_count;
    logic        truncated;
  } out_t;

  function automatic logic [63:0] width_mask(input logic [1:0] sel);
    logic [63:0] m;
    case (sel)
      WSEL_16: m = 64'h0000_0000_0000_FFFF;
      WSEL_32: m = 64'h0000_0000_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] sign_bit(input logic [1:0] sel);
    logic [63:0] s;
    case (sel)
      WSEL_16: s = 64'h0000_0000_0000_8000;
      WSEL_32: s = 64'h0000_0000_8000_0000;
      default: s = 64'h8000_0000_0000_0000;
    endcase
    return s;
  endfunction

  // Cut to width, optionally zigzag decode and sign extend
  function automatic logic [63:0] finish_value(input logic [63:0] acc,
                                               input logic [1:0]  sel,
                                               input logic        zz);
    logic [63:0] m;
    logic [63:0] v;
    m = width_mask(sel);
    v = acc & m;
    if (zz) begin
      v = ((v >> 1) ^ {64{v[0]}}) & m;
      if ((v & sign_bit(sel)) != 64'd0) begin
        v = v | ~m;
      end
    end
    return v;
  endfunction

endpackage

// ----- rtl/varint_zigzag_decoder.sv -----
// ----------------------------------------------------------------------------
// varint_zigzag_decoder
// Gathers LEB128 bytes into a 64-bit value and emits one result word per
// completed value, optionally zigzag decoded and sign extended.
// ----------------------------------------------------------------------------
// out_valid rises once the final byte has passed from the input register into the result register.
// Throughput: one byte per cycle unless a stalled result blocks it; the shift-or into the
// accumulator and the width/zigzag finish both sit in the single stage after the input register.
// Reset (synchronous, rst_n low) empties both registers and clears the
// accumulator, group position and byte count.
module varint_zigzag_decoder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  vz_pkg::in_t   in_word,
  output logic          out_valid,
  input  logic          out_stall,
  output vz_pkg::out_t  out_word
);

  vz_pkg::in_t  in_r;
  logic         in_vld_r;
  logic [63:0]  acc_r, acc_nxt;
  logic [6:0]   shift_r, shift_nxt;
  logic [7:0]   cnt_r, cnt_nxt;
  vz_pkg::out_t out_r, out_nxt;
  logic         out_vld_r;

  logic         adv;
  logic         in_acc;
  logic         more;
  logic         done;
  logic [63:0]  acc_sum;
  logic [6:0]   shift_sum;
  logic [7:0]   cnt_sum;

  assign adv     = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !adv;
  assign in_acc  = in_valid && !in_stall;

  assign more = (in_r.data_byte & vz_pkg::CONT_BIT) != 8'd0;
  assign done = !more || in_r.buffer_end;

  always_comb begin
    acc_sum   = acc_r;
    shift_sum = shift_r;
    if (shift_r < vz_pkg::SHIFT_LIM) begin
      acc_sum   = acc_r | ({57'd0, in_r.data_byte[6:0] & vz_pkg::GROUP_MASK} << shift_r[5:0]);
      shift_sum = shift_r + vz_pkg::GROUP_BITS;
    end
    cnt_sum = (cnt_r == vz_pkg::COUNT_MAX) ? cnt_r : cnt_r + 8'd1;

    acc_nxt   = acc_r;
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    out_nxt   = out_r;
    if (in_vld_r && adv) begin
      if (done) begin
        // value complete: load result, restart gathering
        acc_nxt            = '0;
        shift_nxt          = '0;
        cnt_nxt            = '0;
        out_nxt.value      = vz_pkg::finish_value(acc_sum, in_r.width_sel, in_r.zigzag);
        out_nxt.byte_count = cnt_sum;
        out_nxt.truncated  = more && in_r.buffer_end;
      end else begin
        acc_nxt   = acc_sum;
        shift_nxt = shift_sum;
        cnt_nxt   = cnt_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      acc_r     <= '0;
      shift_r   <= '0;
      cnt_r     <= '0;
    end else begin
      acc_r   <= acc_nxt;
      shift_r <= shift_nxt;
      cnt_r   <= cnt_nxt;
      if (in_acc) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (in_vld_r && adv && done) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_word;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_r;

endmodule

// ----- rtl/vz_checker.sv -----
// ----------------------------------------------------------------------------
// vz_checker
// Port-level checks for the varint decoder, bound to the top level.
// ----------------------------------------------------------------------------
module vz_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_stall,
  input vz_pkg::in_t  in_word,
  input logic         out_valid,
  input logic         out_stall,
  input vz_pkg::out_t out_word
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // a stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("input word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // input backs up only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.byte_count != 8'd0)
    else $error("result with zero byte count");

endmodule

bind varint_zigzag_decoder vz_checker u_vz_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

// ----- sim/tb_varint_zigzag_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_varint_zigzag_decoder
// Self-checking bench for the LEB128 varint decoder. A scoreboard keeps its
// own copy of the accumulator state, predicts the decoded word for every
// closing byte and compares each output word field by field. Stimulus is a
// directed set of edge values followed by random sequences, with bursty
// input traffic and patterned output stalls.
// ----------------------------------------------------------------------------

class varint_scoreboard;
  vz_pkg::out_t decoded_q[$];
  logic [63:0]  acc;
  logic [6:0]   grp_pos;
  logic [7:0]   nbytes;
  int unsigned  fail_count;

  function new();
    acc        = '0;
    grp_pos    = '0;
    nbytes     = '0;
    fail_count = 0;
  endfunction

  function int unsigned outstanding();
    return decoded_q.size();
  endfunction

  // Fold one accepted byte into the predicted state; queue a word on close
  function void take_byte(input vz_pkg::in_t w);
    logic [63:0]  grp;
    logic [63:0]  msk;
    logic [63:0]  sgn;
    logic [63:0]  v;
    logic         more;
    vz_pkg::out_t want;
    more = w.data_byte[7];
    if (grp_pos < vz_pkg::SHIFT_LIM) begin
      grp     = {57'd0, w.data_byte[6:0] & vz_pkg::GROUP_MASK};
      acc     = acc | (grp << grp_pos);
      grp_pos = grp_pos + vz_pkg::GROUP_BITS;
    end
    if (nbytes != vz_pkg::COUNT_MAX) nbytes = nbytes + 8'd1;
    if (more && !w.buffer_end) return;

    case (w.width_sel)
      vz_pkg::WSEL_16: begin
        msk = 64'h0000_0000_0000_FFFF;
        sgn = 64'h0000_0000_0000_8000;
      end
      vz_pkg::WSEL_32: begin
        msk = 64'h0000_0000_FFFF_FFFF;
        sgn = 64'h0000_0000_8000_0000;
      end
      default: begin
        msk = '1;
        sgn = 64'h8000_0000_0000_0000;
      end
    endcase
    v = acc & msk;
    if (w.zigzag) begin
      v = ((v >> 1) ^ (64'd0 - {63'd0, v[0]})) & msk;
      if ((v & sgn) != 64'd0) v = v | ~msk;
    end
    want.value      = v;
    want.byte_count = nbytes;
    want.truncated  = more && w.buffer_end;
    decoded_q.push_back(want);
    acc     = '0;
    grp_pos = '0;
    nbytes  = '0;
  endfunction

  function void compare_value(input vz_pkg::out_t got);
    vz_pkg::out_t want;
    if (decoded_q.size() == 0) begin
      $display("%0t: unexpected output word %h", $time, got);
      fail_count++;
      return;
    end
    want = decoded_q.pop_front();
    if (got.value !== want.value) begin
      $display("%0t: value mismatch expected %h actual %h", $time, want.value, got.value);
      fail_count++;
    end
    if (got.byte_count !== want.byte_count) begin
      $display("%0t: byte_count mismatch expected %0d actual %0d",
               $time, want.byte_count, got.byte_count);
      fail_count++;
    end
    if (got.truncated !== want.truncated) begin
      $display("%0t: truncated mismatch expected %b actual %b",
               $time, want.truncated, got.truncated);
      fail_count++;
    end
  endfunction
endclass

module tb_varint_zigzag_decoder;

  localparam logic [1:0] WSEL_WIDE   = 2'd3;
  localparam int         RAND_ITEMS  = 560;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         HOLD_AFTER  = 300;
  localparam int         HOLD_CYCLES = 400;
  localparam int         DRAIN_CYCLES = 8;

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_stall;
  vz_pkg::in_t  in_word;
  logic         out_valid;
  logic         out_stall;
  vz_pkg::out_t out_word;

  varint_scoreboard sb;
  vz_pkg::in_t      byte_q[$];
  int unsigned      items_accepted;
  int unsigned      cycle_count;
  bit               long_hold_done;

  varint_zigzag_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // n-1 filler bytes with the continuation bit forced, then the tail byte
  task automatic add_run(input int n, input logic [7:0] fill, input logic [7:0] tail,
                         input logic [1:0] sel, input logic zz, input logic tail_end);
    vz_pkg::in_t w;
    for (int i = 0; i < n - 1; i++) begin
      w.data_byte  = fill | vz_pkg::CONT_BIT;
      w.buffer_end = 1'b0;
      w.width_sel  = 2'($urandom);
      w.zigzag     = 1'($urandom);
      byte_q.push_back(w);
    end
    w.data_byte  = tail;
    w.buffer_end = tail_end;
    w.width_sel  = sel;
    w.zigzag     = zz;
    byte_q.push_back(w);
  endtask

  // Well-formed varint with random content; trunc closes on a continuation byte
  task automatic add_varint(input int len, input bit trunc);
    vz_pkg::in_t w;
    for (int i = 0; i < len; i++) begin
      w.data_byte  = 8'($urandom);
      w.width_sel  = 2'($urandom);
      w.zigzag     = 1'($urandom);
      w.buffer_end = 1'b0;
      if (i < len - 1) begin
        w.data_byte[7] = 1'b1;
      end else begin
        w.data_byte[7] = trunc;
        w.buffer_end   = trunc ? 1'b1 : 1'($urandom_range(0, 1));
      end
      byte_q.push_back(w);
    end
  endtask

  task automatic send_word(input vz_pkg::in_t w);
    @(negedge clk);
    in_valid = 1'b1;
    in_word  = w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_byte(w);
    items_accepted++;
  endtask

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // Output monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.compare_value(out_word);
  end

  // Receiver: stall pattern steps through four modes in turn, plus one long hold
  initial begin
    int unsigned cyc;
    int unsigned mode;
    out_stall      = 1'b0;
    long_hold_done = 1'b0;
    cyc            = 0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && items_accepted >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_stall      = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      cyc++;
      mode = (cyc / 50) % 4;
      case (mode)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(0, 3) == 0);
        2: out_stall = ($urandom_range(0, 9) < 6);
        default: out_stall = (cyc % 3 == 0);
      endcase
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** varint_zigzag_decoder: FAILED **");
    $finish;
  end

  initial begin
    int           idx;
    int           burst;
    int           gap;
    int           sel;
    int           directed_len;
    int           pause_at;
    vz_pkg::in_t  w;
    sb             = new();
    items_accepted = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_word        = '0;

    // Directed values: extremes, widths, zigzag, truncation, overflow, saturation
    add_run(1, 8'h00, 8'h00, vz_pkg::WSEL_16, 1'b0, 1'b0);
    add_run(1, 8'h00, 8'h7F, vz_pkg::WSEL_16, 1'b0, 1'b0);
    add_run(1, 8'h00, 8'h7F, vz_pkg::WSEL_16, 1'b1, 1'b0);
    add_run(1, 8'h00, 8'h01, vz_pkg::WSEL_32, 1'b1, 1'b1);
    add_run(2, 8'hFF, 8'h7F, vz_pkg::WSEL_16, 1'b0, 1'b0);
    add_run(3, 8'hFF, 8'h7F, vz_pkg::WSEL_16, 1'b0, 1'b0);
    add_run(3, 8'hFF, 8'h7F, vz_pkg::WSEL_16, 1'b1, 1'b0);
    add_run(3, 8'hFE, 8'h03, vz_pkg::WSEL_16, 1'b1, 1'b0);
    add_run(5, 8'hFF, 8'h0F, vz_pkg::WSEL_32, 1'b0, 1'b0);
    add_run(5, 8'hFF, 8'h0F, vz_pkg::WSEL_32, 1'b1, 1'b0);
    add_run(5, 8'hFE, 8'h0F, vz_pkg::WSEL_32, 1'b1, 1'b0);
    add_run(10, 8'hFF, 8'h01, vz_pkg::WSEL_64, 1'b0, 1'b0);
    add_run(10, 8'hFF, 8'h01, vz_pkg::WSEL_64, 1'b1, 1'b0);
    add_run(10, 8'hFE, 8'h01, vz_pkg::WSEL_64, 1'b1, 1'b0);
    add_run(10, 8'hFF, 8'h7F, WSEL_WIDE, 1'b0, 1'b0);
    add_run(14, 8'hFF, 8'h7F, WSEL_WIDE, 1'b1, 1'b0);
    add_run(1, 8'h00, 8'h80, vz_pkg::WSEL_64, 1'b0, 1'b1);
    add_run(2, 8'hFF, 8'hFF, vz_pkg::WSEL_16, 1'b1, 1'b1);
    add_run(1, 8'h00, 8'hFF, WSEL_WIDE, 1'b1, 1'b1);
    add_run(300, 8'h80, 8'h00, vz_pkg::WSEL_64, 1'b0, 1'b0);
    add_run(256, 8'hFF, 8'hFF, vz_pkg::WSEL_32, 1'b1, 1'b1);
    directed_len = byte_q.size();

    // Random part: mostly well-formed varints, some truncated, some noise
    while (byte_q.size() < directed_len + RAND_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        gap = $urandom_range(0, 99);
        if (gap < 40)      add_varint($urandom_range(1, 3), 1'b0);
        else if (gap < 85) add_varint($urandom_range(4, 10), 1'b0);
        else if (gap < 98) add_varint($urandom_range(11, 14), 1'b0);
        else               add_varint($urandom_range(256, 270), 1'b0);
      end else if (sel < 85) begin
        add_varint($urandom_range(1, 11), 1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          w.data_byte  = 8'($urandom);
          w.buffer_end = ($urandom_range(0, 7) == 0);
          w.width_sel  = 2'($urandom);
          w.zigzag     = 1'($urandom);
          byte_q.push_back(w);
        end
      end
    end
    // Close any open value so the run ends on a completed word
    add_run(1, 8'h00, 8'h00, vz_pkg::WSEL_64, 1'b0, 1'b1);
    pause_at = byte_q.size() / 2;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    idx = 0;
    while (idx < byte_q.size()) begin
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst && idx < byte_q.size(); k++) begin
        if (idx == pause_at) begin
          // hold input until every pending word has drained
          @(negedge clk);
          in_valid = 1'b0;
          while (sb.outstanding() != 0) @(negedge clk);
        end
        send_word(byte_q[idx]);
        idx++;
      end
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      if (gap > 0) hold_off(gap);
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fail_count == 0 && sb.outstanding() == 0) begin
      $display("** varint_zigzag_decoder: PASSED **");
    end else begin
      $display("** varint_zigzag_decoder: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/vz_pkg.sv
rtl/varint_zigzag_decoder.sv
rtl/vz_checker.sv
sim/tb_varint_zigzag_decoder.sv
